### sv/rsra_pkg.sv
// ----------------------------------------------------------------------------
// rsra_pkg
// Shared widths, register codes, controller states and command/status types
// for the return series risk accumulator.
// ----------------------------------------------------------------------------
package rsra_pkg;

   localparam int VALUE_W = 48;
   localparam int RET_W   = 32;
   localparam int DD_W    = 25;
   localparam int WIDE_W  = 64;
   localparam int STEP_W  = 7;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;
   localparam int RSP_W   = 152;
   localparam int USER_W  = 2;

   localparam int FRAC_BITS_DEFAULT  = 24;
   localparam int COUNT_BITS_DEFAULT = 20;

   // register indexes
   localparam logic REG_THRESHOLD = 1'b0;

   localparam logic [WIDE_W-1:0] RET_CAP = 64'h0000_0000_7FFF_FFFF;
   localparam logic [WIDE_W-1:0] DD_CAP  = 64'h0000_0000_01FF_FFFF;
   localparam logic [WIDE_W-1:0] U32_CAP = 64'h0000_0000_FFFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_STEP_WAIT,
      ST_RET,
      ST_ACC,
      ST_SQ,
      ST_SUM,
      ST_FINAL_START,
      ST_FINAL_WAIT,
      ST_ROOT_START,
      ST_ROOT_WAIT,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic accept;
      logic start_step;
      logic upd_ret;
      logic upd_acc;
      logic upd_sq;
      logic upd_sum;
      logic start_final;
      logic start_root;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic root_busy;
      logic last;
      logic out_busy;
   } status_type;

   function automatic logic [WIDE_W-1:0] sat_add(input logic [WIDE_W-1:0] a,
                                                 input logic [WIDE_W-1:0] b);
      logic [WIDE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WIDE_W] ? {WIDE_W{1'b1}} : s[WIDE_W-1:0];
   endfunction

endpackage

### sv/rsra_div.sv
// ----------------------------------------------------------------------------
// rsra_div
// Iterative restoring divider, one quotient bit per cycle, with a saturating
// cap on the quotient. Dividend arrives left aligned; zeros shift in after it.
// ----------------------------------------------------------------------------
module rsra_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rsra_pkg::WIDE_W-1:0]      dividend,
   input  logic [rsra_pkg::WIDE_W-1:0]      divisor,
   input  logic [rsra_pkg::STEP_W-1:0]      steps,
   input  logic [rsra_pkg::WIDE_W-1:0]      cap,
   output logic                             busy,
   output logic [rsra_pkg::WIDE_W-1:0]      quotient
);
   localparam int W = rsra_pkg::WIDE_W;

   logic                          busy_ff, busy_in;
   logic [rsra_pkg::STEP_W-1:0]   cnt_ff, cnt_in;
   logic [W-1:0]                  dv_ff, dv_in;
   logic [W-1:0]                  rem_ff, rem_in;
   logic [W-1:0]                  q_ff, q_in;
   logic [W-1:0]                  d_ff, d_in;
   logic [W-1:0]                  cap_ff, cap_in;
   logic                          sat_ff, sat_in;
   logic [W:0]                    trial;
   logic                          ge;
   logic [W-1:0]                  q_next;

   always_comb begin
      trial  = {rem_ff, dv_ff[W-1]};
      ge     = trial >= {1'b0, d_ff};
      q_next = {q_ff[W-2:0], ge};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dv_in   = dv_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      cap_in  = cap_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         dv_in   = dividend;
         rem_in  = '0;
         q_in    = '0;
         d_in    = divisor;
         cap_in  = cap;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         dv_in  = {dv_ff[W-2:0], 1'b0};
         rem_in = ge ? W'(trial - {1'b0, d_ff}) : trial[W-1:0];
         q_in   = q_next;
         sat_in = sat_ff | (q_next > cap_ff);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rsra_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      dv_ff  <= dv_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      cap_ff <= cap_in;
      sat_ff <= sat_in;
   end

   assign busy     = busy_ff;
   assign quotient = sat_ff ? cap_ff : q_ff;

endmodule

### sv/rsra_sqrt.sv
// ----------------------------------------------------------------------------
// rsra_sqrt
// Floor integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rsra_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rsra_pkg::WIDE_W-1:0]      radicand,
   output logic                             busy,
   output logic [rsra_pkg::RET_W-1:0]       root
);
   localparam int W = rsra_pkg::WIDE_W;

   logic          busy_ff, busy_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  res_ff, res_in;
   logic [W-1:0]  bit_ff, bit_in;
   logic [W-1:0]  trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = radicand;
         res_in  = '0;
         bit_in  = W'(1) << (W - 2);
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[rsra_pkg::RET_W-1:0];

endmodule

### sv/rsra_dpath.sv
// ----------------------------------------------------------------------------
// rsra_dpath
// Series state, two shared dividers, square root unit, accumulators and the
// output register of the return series risk accumulator.
// ----------------------------------------------------------------------------
module rsra_dpath #(
   parameter int FRAC_BITS  = rsra_pkg::FRAC_BITS_DEFAULT,
   parameter int COUNT_BITS = rsra_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rsra_pkg::cmd_type                cmd,
   output rsra_pkg::status_type             status,
   input  logic [rsra_pkg::DATA_W-1:0]      threshold,
   input  logic [rsra_pkg::VALUE_W-1:0]     account_value,
   input  logic                             last_in_series,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rsra_pkg::RSP_W-1:0]       rsp_tdata,
   output logic [rsra_pkg::USER_W-1:0]      rsp_tuser,
   output logic                             rsp_tlast
);
   localparam int VW = rsra_pkg::VALUE_W;
   localparam int W  = rsra_pkg::WIDE_W;
   localparam int RW = rsra_pkg::RET_W;
   localparam int DW = rsra_pkg::DD_W;
   localparam int SW = rsra_pkg::STEP_W;
   localparam logic [SW-1:0] STEPS_VALUE = SW'(VW + FRAC_BITS);
   localparam logic [SW-1:0] STEPS_WIDE  = SW'(W + FRAC_BITS);
   localparam logic [SW-1:0] STEPS_MEAN  = SW'(W);
   localparam int PAD = W - VW;

   // item and series state
   logic [VW-1:0]          v_ff;
   logic                   last_ff;
   logic [VW-1:0]          prev_ff;
   logic                   have_ff;
   logic [VW-1:0]          peak_ff;
   logic [DW-1:0]          worst_ff;
   logic [W-1:0]           gain_ff, loss_ff, sq_ff;
   logic [COUNT_BITS-1:0]  cnt_ff;
   logic                   neg_ff, dd_ok_ff, acc_en_ff, short_ff;
   logic [RW-1:0]          ret_ff;
   logic [DW-1:0]          dd_ff;
   logic                   rv_ff, de_ff;
   logic [RW:0]            diff_ff;
   logic [RW-1:0]          m_ff;
   logic [W-1:0]           prod_ff;
   logic [RW-1:0]          omega_ff;
   // output register
   logic                   out_valid_ff;
   logic [RW-1:0]          o_ret_ff, o_omega_ff, o_down_ff;
   logic [DW-1:0]          o_dd_ff, o_worst_ff;
   logic                   o_rv_ff, o_final_ff, o_de_ff;

   // divider and root hookup
   logic                   start_a, start_b, busy_a, busy_b, root_busy;
   logic [W-1:0]           a_dividend, a_divisor, a_cap, b_dividend, b_divisor, b_cap;
   logic [SW-1:0]          a_steps, b_steps;
   logic [W-1:0]           qa, qb;
   logic [W-1:0]           radicand;
   logic [RW-1:0]          root;

   logic [VW-1:0]          peak_new;
   logic                   dd_ok_new;
   logic [VW-1:0]          ret_num, dd_num;
   logic [RW-1:0]          ret_mag, ret_c;
   logic [DW-1:0]          dd_c;
   logic [RW:0]            diff_c, ndiff;
   logic                   diff_pos, diff_neg;

   always_comb begin
      peak_new  = have_ff ? ((v_ff > peak_ff) ? v_ff : peak_ff) : v_ff;
      dd_ok_new = v_ff < peak_new;
      ret_num   = (v_ff >= prev_ff) ? (v_ff - prev_ff) : (prev_ff - v_ff);
      dd_num    = dd_ok_new ? (peak_new - v_ff) : '0;

      start_a = cmd.start_step | cmd.start_final;
      start_b = start_a;
      if (cmd.start_final) begin
         a_dividend = gain_ff;
         a_divisor  = loss_ff;
         a_steps    = STEPS_WIDE;
         a_cap      = rsra_pkg::U32_CAP;
         b_dividend = sq_ff;
         b_divisor  = W'(cnt_ff);
         b_steps    = STEPS_MEAN;
         b_cap      = '1;
      end else begin
         a_dividend = {ret_num, {PAD{1'b0}}};
         a_divisor  = W'(prev_ff);
         a_steps    = STEPS_VALUE;
         a_cap      = rsra_pkg::RET_CAP;
         b_dividend = {dd_num, {PAD{1'b0}}};
         b_divisor  = W'(peak_new);
         b_steps    = STEPS_VALUE;
         b_cap      = rsra_pkg::DD_CAP;
      end

      ret_mag = qa[RW-1:0];
      if (!have_ff) begin
         ret_c = '0;
      end else if (prev_ff == '0) begin
         ret_c = (v_ff != '0) ? rsra_pkg::RET_CAP[RW-1:0] : '0;
      end else begin
         ret_c = neg_ff ? (~ret_mag + 1'b1) : ret_mag;
      end
      dd_c   = dd_ok_ff ? qb[DW-1:0] : '0;
      diff_c = {ret_c[RW-1], ret_c} - {threshold[RW-1], threshold};

      diff_neg = diff_ff[RW];
      diff_pos = !diff_neg && (diff_ff != '0);
      ndiff    = ~diff_ff + 1'b1;
      radicand = (cnt_ff != '0) ? qb : '0;
   end

   rsra_div u_div_a (
      .clock    (clock),
      .reset    (reset),
      .start    (start_a),
      .dividend (a_dividend),
      .divisor  (a_divisor),
      .steps    (a_steps),
      .cap      (a_cap),
      .busy     (busy_a),
      .quotient (qa)
   );

   rsra_div u_div_b (
      .clock    (clock),
      .reset    (reset),
      .start    (start_b),
      .dividend (b_dividend),
      .divisor  (b_divisor),
      .steps    (b_steps),
      .cap      (b_cap),
      .busy     (busy_b),
      .quotient (qb)
   );

   rsra_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_root),
      .radicand (radicand),
      .busy     (root_busy),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         prev_ff      <= '0;
         peak_ff      <= '0;
         worst_ff     <= '0;
         gain_ff      <= '0;
         loss_ff      <= '0;
         sq_ff        <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.start_step) begin
            peak_ff <= peak_new;
         end
         if (cmd.upd_ret) begin
            worst_ff <= (dd_c > worst_ff) ? dd_c : worst_ff;
            prev_ff  <= v_ff;
            have_ff  <= 1'b1;
         end
         if (cmd.upd_acc && acc_en_ff) begin
            if (diff_pos) begin
               gain_ff <= rsra_pkg::sat_add(gain_ff, W'(diff_ff[RW-1:0]));
            end else begin
               loss_ff <= rsra_pkg::sat_add(loss_ff, W'(ndiff[RW-1:0]));
            end
         end
         if (cmd.upd_sum && short_ff) begin
            sq_ff <= rsra_pkg::sat_add(sq_ff, prod_ff);
            if (cnt_ff != '1) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
            // close the series
            if (last_ff) begin
               have_ff  <= 1'b0;
               prev_ff  <= '0;
               peak_ff  <= '0;
               worst_ff <= '0;
               gain_ff  <= '0;
               loss_ff  <= '0;
               sq_ff    <= '0;
               cnt_ff   <= '0;
            end
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end

      if (cmd.accept) begin
         v_ff    <= account_value;
         last_ff <= last_in_series;
      end
      if (cmd.start_step) begin
         neg_ff   <= v_ff < prev_ff;
         dd_ok_ff <= dd_ok_new;
      end
      if (cmd.upd_ret) begin
         ret_ff    <= ret_c;
         dd_ff     <= dd_c;
         rv_ff     <= have_ff;
         de_ff     <= have_ff && (prev_ff == '0);
         diff_ff   <= diff_c;
         acc_en_ff <= have_ff;
      end
      if (cmd.upd_acc) begin
         m_ff     <= ndiff[RW-1:0];
         short_ff <= acc_en_ff && diff_neg;
      end
      if (cmd.upd_sq) begin
         prod_ff <= W'(m_ff) * W'(m_ff);
      end
      if (cmd.start_root) begin
         omega_ff <= (loss_ff != '0) ? qa[RW-1:0] : '0;
      end
      if (cmd.load_out) begin
         o_ret_ff   <= ret_ff;
         o_rv_ff    <= rv_ff;
         o_dd_ff    <= dd_ff;
         o_worst_ff <= worst_ff;
         o_omega_ff <= last_ff ? omega_ff : '0;
         o_down_ff  <= last_ff ? root : '0;
         o_final_ff <= last_ff;
         o_de_ff    <= de_ff;
      end
   end

   always_comb begin
      status.div_busy  = busy_a | busy_b;
      status.root_busy = root_busy;
      status.last      = last_ff;
      status.out_busy  = out_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(rsra_pkg::RSP_W - 3*RW - 2*DW){1'b0}},
                        o_down_ff, o_omega_ff, o_worst_ff, o_dd_ff, o_ret_ff};
   assign rsp_tuser  = {o_de_ff, o_rv_ff};
   assign rsp_tlast  = o_final_ff;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_tready))
      else $error("result register overwritten while held");
   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_final || cmd.start_step) |-> !(busy_a || busy_b || root_busy))
      else $error("divider restarted while busy");
   a_seeded: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_ret |=> have_ff)
      else $error("series not seeded after step");
`endif

endmodule

### sv/rsra_ctrl.sv
// ----------------------------------------------------------------------------
// rsra_ctrl
// Sequencer: steps one item through division, accumulation and, on the last
// item of a series, the omega division and downside root.
// ----------------------------------------------------------------------------
module rsra_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  rsra_pkg::status_type  status,
   output rsra_pkg::cmd_type     cmd
);
   rsra_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsra_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = rsra_pkg::ST_START;
         end
         rsra_pkg::ST_START:      state_in = rsra_pkg::ST_STEP_WAIT;
         rsra_pkg::ST_STEP_WAIT: begin
            if (!status.div_busy) state_in = rsra_pkg::ST_RET;
         end
         rsra_pkg::ST_RET:        state_in = rsra_pkg::ST_ACC;
         rsra_pkg::ST_ACC:        state_in = rsra_pkg::ST_SQ;
         rsra_pkg::ST_SQ:         state_in = rsra_pkg::ST_SUM;
         rsra_pkg::ST_SUM: begin
            state_in = status.last ? rsra_pkg::ST_FINAL_START : rsra_pkg::ST_LOAD;
         end
         rsra_pkg::ST_FINAL_START: state_in = rsra_pkg::ST_FINAL_WAIT;
         rsra_pkg::ST_FINAL_WAIT: begin
            if (!status.div_busy) state_in = rsra_pkg::ST_ROOT_START;
         end
         rsra_pkg::ST_ROOT_START: state_in = rsra_pkg::ST_ROOT_WAIT;
         rsra_pkg::ST_ROOT_WAIT: begin
            if (!status.root_busy) state_in = rsra_pkg::ST_LOAD;
         end
         rsra_pkg::ST_LOAD: begin
            if (!status.out_busy) state_in = rsra_pkg::ST_IDLE;
         end
         default:                 state_in = rsra_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         rsra_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         rsra_pkg::ST_START:       cmd.start_step  = 1'b1;
         rsra_pkg::ST_RET:         cmd.upd_ret     = 1'b1;
         rsra_pkg::ST_ACC:         cmd.upd_acc     = 1'b1;
         rsra_pkg::ST_SQ:          cmd.upd_sq      = 1'b1;
         rsra_pkg::ST_SUM:         cmd.upd_sum     = 1'b1;
         rsra_pkg::ST_FINAL_START: cmd.start_final = 1'b1;
         rsra_pkg::ST_ROOT_START:  cmd.start_root  = 1'b1;
         rsra_pkg::ST_LOAD:        cmd.load_out    = !status.out_busy;
         default:                  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsra_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/return_series_risk_accumulator_unit.sv
// ----------------------------------------------------------------------------
// return_series_risk_accumulator_unit
// Account value stream in; per-item return, drawdown and series risk out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one account value per transaction; tlast closes a series.
//          The first value of a series only seeds the previous value and peak.
//   rsp_*  carries one result per accepted transaction: daily return, current
//          and maximum drawdown, and on the series' last item the omega ratio
//          and downside risk (tlast high).
//   csr_*  holds the return threshold (register 0); write it while idle.
// Processing: one item at a time. An ordinary item is paced by two
//   bit-serial dividers working side by side over 48 + FRAC_BITS quotient
//   bits. A series' last item adds the omega division (64 + FRAC_BITS
//   bits) and the 32-step root.
// Reset: clears the series state, the threshold and the output valid flag.
// Stall: a result waits in the output register while the next item is
//   accepted and processed; the block holds in its load step only if that
//   register is still occupied.
// ----------------------------------------------------------------------------
module return_series_risk_accumulator_unit #(
   parameter int FRAC_BITS  = rsra_pkg::FRAC_BITS_DEFAULT,
   parameter int COUNT_BITS = rsra_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // input stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rsra_pkg::VALUE_W-1:0]     req_tdata,   // [47:0] account_value
   input  logic                             req_tlast,   // last_in_series
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] daily_return, [56:32] drawdown, [81:57] worst_drawdown,
   // [113:82] gain_loss_ratio, [145:114] downside_deviation, [151:146] zero
   output logic [rsra_pkg::RSP_W-1:0]       rsp_tdata,
   output logic [rsra_pkg::USER_W-1:0]      rsp_tuser,   // [0] return_valid, [1] divide_error
   output logic                             rsp_tlast,   // final_valid
   // configuration
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rsra_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [rsra_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [rsra_pkg::DATA_W-1:0]      csr_prdata,
   output logic                             csr_pready
);
   rsra_pkg::cmd_type    cmd;
   rsra_pkg::status_type status;

   logic [rsra_pkg::DATA_W-1:0] threshold_ff;
   logic                        reg_hit;

   // register index sits in the word address bit
   assign reg_hit    = csr_paddr[2] == rsra_pkg::REG_THRESHOLD;
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? threshold_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         threshold_ff <= csr_pwdata;
      end
   end

   rsra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rsra_dpath #(
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .threshold      (threshold_ff),
      .account_value  (req_tdata),
      .last_in_series (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast)
   );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the return series risk accumulator: account value
// series go in, and every result is checked against a cycle-free predictor of
// returns, drawdowns, omega ratio and downside risk, over several thresholds
// and idling patterns.
// ----------------------------------------------------------------------------
module testbench;

   localparam int FRAC       = rsra_pkg::FRAC_BITS_DEFAULT;
   localparam int CNT_BITS   = rsra_pkg::COUNT_BITS_DEFAULT;
   localparam int VALUE_W    = rsra_pkg::VALUE_W;
   localparam int RSP_W      = rsra_pkg::RSP_W;
   localparam int USER_W     = rsra_pkg::USER_W;
   localparam int ADDR_W     = rsra_pkg::ADDR_W;
   localparam int DATA_W     = rsra_pkg::DATA_W;
   localparam int CYCLE_CAP  = 1000000;
   localparam int SETTLE     = 250;   // one final item plus margin

   typedef struct packed {
      logic [31:0] ret;
      logic        ret_ok;
      logic [24:0] dd;
      logic [24:0] max_dd;
      logic [31:0] omega;
      logic [31:0] down;
      logic        closing;
      logic        div_err;
   } risk_result_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               closes;
   } account_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata = '0;
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic [USER_W-1:0]   rsp_tuser;
   logic                rsp_tlast;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [DATA_W-1:0]   csr_pwdata = '0;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   // predictor copy of the block's threshold and series state
   int                  threshold;
   logic [63:0]         last_value, peak, worst_dd;
   logic                seeded;
   logic [63:0]         gains, losses, square_sum, short_count;

   account_item_type    pending_values[$];
   risk_result_type     expected_results[$];
   int                  failures = 0;
   int                  cycle_count = 0;
   int                  sender_idle_pct = 0;
   int                  receiver_stall_pct = 0;
   int                  hold_left = 0;
   bit                  offer_taken = 1'b0;

   return_series_risk_accumulator_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // floor(n * 2^FRAC / d), clipped to cap; d is never zero here
   function automatic logic [63:0] scaled_quotient(logic [63:0] n, logic [63:0] d,
                                                   logic [63:0] cap);
      logic [127:0] q;
      q = ({64'b0, n} << FRAC) / {64'b0, d};
      if (q > {64'b0, cap}) return cap;
      return q[63:0];
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] clip_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic void clear_series();
      last_value = 0; seeded = 0; peak = 0; worst_dd = 0;
      gains = 0; losses = 0; square_sum = 0; short_count = 0;
   endfunction

   // advance the predicted state by one value and queue the result it causes
   function automatic void predict_risk(logic [VALUE_W-1:0] value, logic closes);
      risk_result_type r;
      longint          ret, diff;
      logic [63:0]     v, m, dd;
      r = '0;
      v = {16'b0, value};
      ret = 0;
      dd = 0;
      if (seeded) begin
         r.ret_ok = 1'b1;
         if (last_value == 0) begin
            r.div_err = 1'b1;
            ret = (v != 0) ? longint'(rsra_pkg::RET_CAP) : 0;
         end else if (v >= last_value) begin
            ret = longint'(scaled_quotient(v - last_value, last_value, rsra_pkg::RET_CAP));
         end else begin
            ret = -longint'(scaled_quotient(last_value - v, last_value, rsra_pkg::RET_CAP));
         end
         diff = ret - longint'(threshold);
         if (diff > 0) gains = clip_add(gains, diff);
         else losses = clip_add(losses, -diff);
         if (diff < 0) begin
            m = -diff;
            square_sum = clip_add(square_sum, m * m);
            if (short_count < (64'd1 << CNT_BITS) - 1) short_count++;
         end
         if (v > peak) peak = v;
      end else begin
         peak = v;
      end
      if (peak != 0 && v < peak) dd = scaled_quotient(peak - v, peak, rsra_pkg::DD_CAP);
      if (dd > worst_dd) worst_dd = dd;
      last_value = v;
      seeded = 1'b1;
      r.ret = ret[31:0];
      r.dd = dd[24:0];
      r.max_dd = worst_dd[24:0];
      if (closes) begin
         if (losses != 0) r.omega = 32'(scaled_quotient(gains, losses, rsra_pkg::U32_CAP));
         if (short_count != 0) r.down = 32'(floor_root(square_sum / short_count));
         r.closing = 1'b1;
         clear_series();
      end
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   // monitor: predict on every accepted input, check every accepted result
   always @(posedge clock) begin
      risk_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("simulation failed");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_risk(req_tdata, req_tlast);
            offer_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with nothing expected");
               failures++;
            end else begin
               want = expected_results.pop_front();
               compare_field("daily_return", 64'(want.ret), 64'(rsp_tdata[31:0]));
               compare_field("drawdown", 64'(want.dd), 64'(rsp_tdata[56:32]));
               compare_field("worst_drawdown", 64'(want.max_dd), 64'(rsp_tdata[81:57]));
               compare_field("gain_loss_ratio", 64'(want.omega), 64'(rsp_tdata[113:82]));
               compare_field("downside_deviation", 64'(want.down),
                             64'(rsp_tdata[145:114]));
               compare_field("return_valid", 64'(want.ret_ok), 64'(rsp_tuser[0]));
               compare_field("divide_error", 64'(want.div_err), 64'(rsp_tuser[1]));
               compare_field("final_valid", 64'(want.closing), 64'(rsp_tlast));
            end
         end
      end
   end

   // driver: offer the next pending value once the current transaction is taken
   always @(negedge clock) begin
      account_item_type item;
      if (!reset && (!req_tvalid || offer_taken)) begin
         offer_taken = 1'b0;
         if (pending_values.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            item = pending_values.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.value;
            req_tlast  <= item.closes;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic write_threshold(int value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= ADDR_W'(rsra_pkg::REG_THRESHOLD) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      threshold = value;
   endtask

   // hold until every value is sent and every result has come back
   task automatic drain();
      while (pending_values.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void add_value(logic [VALUE_W-1:0] value, logic closes);
      account_item_type item;
      item.value = value;
      item.closes = closes;
      pending_values.insert(pending_values.size(), item);
   endfunction

   // random walk with occasional jumps to extremes, zero and full range
   function automatic logic [VALUE_W-1:0] next_value(logic [VALUE_W-1:0] prev);
      int unsigned pick;
      logic [VALUE_W-1:0] step;
      pick = $urandom_range(99);
      if (pick < 10 || prev == 0) return VALUE_W'({$urandom, $urandom} >> $urandom_range(47));
      if (pick < 15) return '0;
      if (pick < 18) return '1;
      if (pick < 21) return VALUE_W'(1);
      step = prev >> $urandom_range(2, 14);
      step = VALUE_W'(step * $urandom_range(3));
      if ($urandom_range(1)) return prev + step;
      return prev - step;
   endfunction

   task automatic queue_series(int count);
      logic [VALUE_W-1:0] v;
      int len;
      v = VALUE_W'({$urandom, $urandom});
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) begin
            // noise: lone values, and series cut short
            add_value(VALUE_W'({$urandom, $urandom}), 1'($urandom_range(1)));
         end else begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
               v = next_value(v);
               add_value(v, k == len - 1);
            end
            i += len - 1;
         end
      end
   endtask

   initial begin
      int thresholds[8];
      clear_series();
      threshold = 0;
      thresholds = '{0, 32'h8000_0000, 32'h7FFF_FFFF, 1 << FRAC,
                     -(1 << 20), 0, 0, 32'h0100_0000};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: seed-only series, zero previous values, extremes, flat curve
      write_threshold(0);
      add_value(48'd1000, 1'b1);
      add_value(48'd0, 1'b0); add_value(48'd5, 1'b0); add_value(48'd0, 1'b0);
      add_value(48'd0, 1'b1);
      add_value('1, 1'b0); add_value(48'd1, 1'b0); add_value('1, 1'b1);
      add_value(48'd1, 1'b0); add_value('1, 1'b0); add_value(48'd2, 1'b1);
      add_value(48'd700, 1'b0); add_value(48'd700, 1'b0); add_value(48'd700, 1'b1);
      add_value(48'd100, 1'b0); add_value(48'd120, 1'b0); add_value(48'd90, 1'b0);
      add_value(48'd95, 1'b1);
      drain();

      // threshold at the top: every return falls short and the sums saturate
      write_threshold(32'h7FFF_FFFF);
      add_value('1, 1'b0); add_value(48'd1, 1'b0); add_value(48'd1, 1'b0);
      add_value(48'd0, 1'b0); add_value(48'd0, 1'b1);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         if (thresholds[phase] == 0 && phase > 0) write_threshold(int'($urandom));
         else write_threshold(thresholds[phase]);
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
            default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
         endcase
         // long hold-off: fill the block until it refuses input
         if (phase == 4) hold_left = 2000;
         queue_series(48);
         drain();
      end

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (SETTLE) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
sv/rsra_pkg.sv
sv/rsra_div.sv
sv/rsra_sqrt.sv
sv/rsra_dpath.sv
sv/rsra_ctrl.sv
sv/return_series_risk_accumulator_unit.sv
tb/testbench.sv
